[rtl/core/link_reconnect_supervisor_defines.svh]
// ----------------------------------------------------------------------------
// Link reconnect supervisor assertion macros
// Shared property forms for the supervisor's checker.
// ----------------------------------------------------------------------------
`ifndef LINK_RECONNECT_SUPERVISOR_DEFINES_SVH
`define LINK_RECONNECT_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect supervisor package
// Types, codes and register indexes shared by the supervisor modules.
// ----------------------------------------------------------------------------
package lrs_pkg;

  // Request kinds
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_e;

  // Radio link status
  typedef enum logic [1:0] {
    LINK_DOWN       = 2'd0,
    LINK_CONNECTING = 2'd1,
    LINK_UP         = 2'd2,
    LINK_FAULT      = 2'd3
  } link_status_e;

  // Supervisor state, also reported on every result word
  typedef enum logic [2:0] {
    LS_DISABLED     = 3'd0,
    LS_CONNECTING   = 3'd1,
    LS_CONNECTED    = 3'd2,
    LS_DISCONNECTED = 3'd3,
    LS_ERROR        = 3'd4
  } link_state_e;

  localparam logic [1:0] REASON_OTHER = 2'd0;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_STATION_ENABLE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_RETRY         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FAST_RETRY_ENABLE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_INTERVAL_MS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FAST_INTERVAL_MS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CONNECT_TIMEOUT_MS = 3'd5;

  localparam logic [31:0] RETRY_INTERVAL_RESET = 32'd5000;

  typedef struct packed {
    logic        station_enable;
    logic        auto_retry;
    logic        fast_retry_enable;
    logic [31:0] retry_interval_ms;
    logic [31:0] fast_interval_ms;
    logic [31:0] connect_timeout_ms;
  } lrs_cfg_t;

  typedef struct packed {
    req_type_e         req_type;
    logic [31:0]       now_ms;
    link_status_e      link_status;
    logic [1:0]        drop_reason;
    logic              retry_accepted;
    logic              start_accepted;
    logic [31:0]       local_address;
    logic signed [7:0] signal_in;
  } lrs_in_t;

  typedef struct packed {
    link_state_e       link_state;
    logic              start_ok;
    logic              retry_request;
    logic [31:0]       retry_total;
    logic [31:0]       address_out;
    logic signed [7:0] signal_out;
    logic [31:0]       uptime_ms;
  } lrs_out_t;

  typedef struct packed {
    link_state_e       station_state;
    logic              configured;
    logic [31:0]       connected_since;
    logic              connected_since_valid;
    logic [31:0]       connect_started;
    logic [31:0]       anchor_time;
    logic              anchor_valid;
    logic [31:0]       active_interval;
    logic [31:0]       retry_counter;
    logic [31:0]       held_address;
    logic signed [7:0] held_signal;
  } lrs_state_t;

  localparam lrs_state_t STATE_RESET = '{
    station_state:         LS_DISABLED,
    configured:            1'b0,
    connected_since:       32'd0,
    connected_since_valid: 1'b0,
    connect_started:       32'd0,
    anchor_time:           32'd0,
    anchor_valid:          1'b0,
    active_interval:       32'd0,
    retry_counter:         32'd0,
    held_address:          32'd0,
    held_signal:           8'sd0
  };

endpackage

[rtl/core/link_reconnect_supervisor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect supervisor
// Tracks a station link and issues timed reconnect requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (start or tick) enter on in_valid_i / in_stall_o; one result
//   word per request leaves on out_valid_o / out_stall_i, in request order.
//   A word moves when valid is high and stall is low at a rising clock edge.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i);
//   write only while no request is in flight. Unknown indexes are dropped.
//   Timing: a word accepted into the input register has its result loaded
//   into the result register when it advances (input register, then result
//   register). Throughput: one word per cycle while the receiver does not
//   stall, set by the combinational step logic between the two registers.
//   Reset returns the configuration registers to their defaults, puts the
//   supervisor in the disabled, unconfigured state and empties both
//   pipeline registers.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word; after that in_stall_o rises.
// ----------------------------------------------------------------------------
module link_reconnect_supervisor
  import lrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lrs_in_t            in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lrs_out_t           out_word_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);

  lrs_cfg_t   cfg;
  lrs_state_t state_q, state_d;
  lrs_out_t   result;

  logic       in_valid_q, in_valid_d;
  lrs_in_t    in_word_q;
  logic       out_valid_q, out_valid_d;
  lrs_out_t   out_word_q;
  logic       in_take;
  logic       advance;

  lrs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Step logic works on the word in the input register
  lrs_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .word_i   (in_word_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Advance when the result register is empty or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      // Commit the supervisor state only as the word moves on
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: load on the handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/core/lrs_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect supervisor configuration registers
// Write-only register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lrs_cfg_regs
  import lrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  output lrs_cfg_t           cfg_o
);

  lrs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STATION_ENABLE:     cfg_d.station_enable     = cfg_wdata_i[0];
        CFG_AUTO_RETRY:         cfg_d.auto_retry         = cfg_wdata_i[0];
        CFG_FAST_RETRY_ENABLE:  cfg_d.fast_retry_enable  = cfg_wdata_i[0];
        CFG_RETRY_INTERVAL_MS:  cfg_d.retry_interval_ms  = cfg_wdata_i;
        CFG_FAST_INTERVAL_MS:   cfg_d.fast_interval_ms   = cfg_wdata_i;
        CFG_CONNECT_TIMEOUT_MS: cfg_d.connect_timeout_ms = cfg_wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station_enable     <= 1'b1;
      cfg_q.auto_retry         <= 1'b1;
      cfg_q.fast_retry_enable  <= 1'b0;
      cfg_q.retry_interval_ms  <= RETRY_INTERVAL_RESET;
      cfg_q.fast_interval_ms   <= 32'd0;
      cfg_q.connect_timeout_ms <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/lrs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect supervisor step logic
// Next supervisor state and result word for one request word.
// ----------------------------------------------------------------------------
module lrs_step
  import lrs_pkg::*;
(
  input  lrs_state_t state_i,
  input  lrs_cfg_t   cfg_i,
  input  lrs_in_t    word_i,
  output lrs_state_t state_o,
  output lrs_out_t   result_o
);

  logic [31:0] conn_elapsed;
  logic [31:0] anchor_elapsed;
  logic [31:0] uptime;
  logic        go_down;
  logic        down_err;
  logic        retry_req;
  logic        start_ok;
  logic        up;
  lrs_state_t  s;

  assign conn_elapsed   = word_i.now_ms - state_i.connect_started;
  assign anchor_elapsed = word_i.now_ms - state_i.anchor_time;

  always_comb begin
    s         = state_i;
    go_down   = 1'b0;
    down_err  = 1'b0;
    retry_req = 1'b0;
    start_ok  = 1'b0;

    if (word_i.req_type == REQ_START) begin
      // Re-initialize everything, then check the configuration
      s                       = STATE_RESET;
      s.active_interval       = cfg_i.retry_interval_ms;
      if (cfg_i.station_enable && cfg_i.auto_retry && (cfg_i.retry_interval_ms == 32'd0)) begin
        s.station_state = LS_ERROR;
      end else begin
        s.configured = 1'b1;
        priority if (!cfg_i.station_enable) begin
          start_ok = 1'b1;
        end else if (!word_i.start_accepted) begin
          s.station_state = LS_ERROR;
        end else begin
          s.station_state = LS_CONNECTING;
          start_ok        = 1'b1;
        end
      end
    end else if (state_i.configured && cfg_i.station_enable) begin
      unique case (word_i.link_status)
        LINK_UP: begin
          if (state_i.station_state != LS_CONNECTED) begin
            s.connected_since       = word_i.now_ms;
            s.connected_since_valid = 1'b1;
          end
          s.station_state   = LS_CONNECTED;
          s.anchor_valid    = 1'b0;
          s.connect_started = 32'd0;
          s.held_address    = word_i.local_address;
          s.held_signal     = word_i.signal_in;
        end
        LINK_CONNECTING: begin
          s.station_state         = LS_CONNECTING;
          s.held_address          = 32'd0;
          s.held_signal           = 8'sd0;
          s.connected_since       = 32'd0;
          s.connected_since_valid = 1'b0;
          if (state_i.connect_started == 32'd0) begin
            s.connect_started = word_i.now_ms;
          end else if ((cfg_i.connect_timeout_ms != 32'd0) &&
                       (conn_elapsed >= cfg_i.connect_timeout_ms)) begin
            go_down = 1'b1;
          end
        end
        LINK_DOWN: go_down = 1'b1;
        LINK_FAULT: begin
          go_down  = 1'b1;
          down_err = 1'b1;
        end
        default: go_down = 1'b1;
      endcase
    end

    if (go_down) begin
      s.held_address          = 32'd0;
      s.held_signal           = 8'sd0;
      s.connected_since       = 32'd0;
      s.connected_since_valid = 1'b0;
      s.connect_started       = 32'd0;
      s.station_state         = down_err ? LS_ERROR : LS_DISCONNECTED;
      if (!state_i.anchor_valid) begin
        // First down tick: arm the anchor and pick the wait
        s.anchor_time  = word_i.now_ms;
        s.anchor_valid = 1'b1;
        if (cfg_i.fast_retry_enable && (word_i.drop_reason != REASON_OTHER) &&
            (cfg_i.fast_interval_ms != 32'd0)) begin
          s.active_interval = cfg_i.fast_interval_ms;
        end else begin
          s.active_interval = cfg_i.retry_interval_ms;
        end
      end else if (cfg_i.auto_retry && (anchor_elapsed >= state_i.active_interval)) begin
        s.anchor_time   = word_i.now_ms;
        s.anchor_valid  = 1'b0;
        s.retry_counter = state_i.retry_counter + 32'd1;
        retry_req       = 1'b1;
        if (word_i.retry_accepted) begin
          s.station_state   = LS_CONNECTING;
          s.connect_started = word_i.now_ms;
        end else begin
          s.station_state = LS_ERROR;
        end
      end
    end
  end

  assign up     = (s.station_state == LS_CONNECTED);
  assign uptime = word_i.now_ms - s.connected_since;

  assign state_o                = s;
  assign result_o.link_state    = s.station_state;
  assign result_o.start_ok      = start_ok;
  assign result_o.retry_request = retry_req;
  assign result_o.retry_total   = s.retry_counter;
  assign result_o.address_out   = up ? s.held_address : 32'd0;
  assign result_o.signal_out    = up ? s.held_signal : 8'sd0;
  assign result_o.uptime_ms     = (up && s.connected_since_valid) ? uptime : 32'd0;

endmodule

[rtl/core/lrs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect supervisor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "link_reconnect_supervisor_defines.svh"

module lrs_checker
  import lrs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input lrs_out_t out_word_o
);

  // A successful start leaves the link connecting or disabled
  `LRS_ASSERT_IMPL(a_start_ok_state, clk_i, rst_ni, out_valid_o && out_word_o.start_ok, (out_word_o.link_state == LS_CONNECTING) || (out_word_o.link_state == LS_DISABLED), "start_ok with unexpected link state")

  // A reconnect request lands in connecting or error, never on a start word
  `LRS_ASSERT_IMPL(a_retry_state, clk_i, rst_ni, out_valid_o && out_word_o.retry_request, !out_word_o.start_ok && ((out_word_o.link_state == LS_CONNECTING) || (out_word_o.link_state == LS_ERROR)), "retry_request with unexpected link state")

  // Latched link data only shows while connected
  `LRS_ASSERT_IMPL(a_idle_fields_zero, clk_i, rst_ni, out_valid_o && (out_word_o.link_state != LS_CONNECTED), (out_word_o.address_out == 32'd0) && (out_word_o.signal_out == 8'sd0) && (out_word_o.uptime_ms == 32'd0), "link data shown while not connected")

  // Stalled result word holds
  `LRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled result word changed")

endmodule

bind link_reconnect_supervisor lrs_checker u_lrs_checker (.*);
